>>> sv/cer_pkg.sv
// shared types and constants for the cosine eased velocity ramp
// no dependencies; used by every module of the block
`default_nettype none

package cer_pkg;

    localparam int MAX_JOINTS = 7;
    localparam int W_BITS     = 17;
    localparam int W_FRAC     = 16;

    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_VEL_W     = 15;
    localparam logic [MAX_VEL_W-1:0] MAX_VEL_RESET = 15'd4096;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_VEL = 1'b0;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] HALF_Q30 = 64'd536870912;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic stop;
    } cer_ctl_t;

endpackage

`default_nettype wire

>>> sv/cer_weight_rom.sv
// cosine easing weight rom, unsigned q1.16, filled at elaboration
// depends on cer_pkg
`default_nettype none

module cer_weight_rom #(
    parameter int RAMP_STEPS = 256
) (
    input  wire logic                                aclk,
    input  wire logic [$clog2(RAMP_STEPS+1)-1:0]     rd_addr,
    output logic      [cer_pkg::W_BITS-1:0]          weight
);

    typedef logic [cer_pkg::W_BITS-1:0] rom_arr_t [RAMP_STEPS+1];

    function automatic logic [63:0] qmul(input logic [63:0] x, input logic [63:0] y);
        return (x * y + cer_pkg::HALF_Q30) >> 30;
    endfunction

    function automatic logic [63:0] lower_w(input logic [63:0] k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        a  = (k * cer_pkg::PI_Q30 + 64'(RAMP_STEPS)) / 64'(2 * RAMP_STEPS);
        a2 = qmul(a, a);
        t  = a;
        s  = a;
        t  = (qmul(t, a2) + 64'd3) / 64'd6;
        s  = s - t;
        t  = (qmul(t, a2) + 64'd10) / 64'd20;
        s  = s + t;
        t  = (qmul(t, a2) + 64'd21) / 64'd42;
        s  = s - t;
        t  = (qmul(t, a2) + 64'd36) / 64'd72;
        s  = s + t;
        t  = (qmul(t, a2) + 64'd55) / 64'd110;
        s  = s - t;
        return (s * s + (64'd1 << 43)) >> 44;
    endfunction

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        for (int k = 0; k <= RAMP_STEPS; k++) begin
            if (RAMP_STEPS <= 1) begin
                r[k] = 17'h10000;
            end else if (2 * k <= RAMP_STEPS) begin
                r[k] = cer_pkg::W_BITS'(lower_w(64'(k)));
            end else begin
                r[k] = cer_pkg::W_BITS'(64'h10000 - lower_w(64'(RAMP_STEPS - k)));
            end
        end
        return r;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    logic [cer_pkg::W_BITS-1:0] weight_reg;

    always_ff @(posedge aclk) begin
        weight_reg <= ROM[rd_addr];
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

>>> sv/cer_joint.sv
// one joint lane: clamp, ramp state and weighted interpolation
// depends on cer_pkg
`default_nettype none

module cer_joint #(
    parameter int VEL_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cer_pkg::cer_ctl_t           ctl,
    input  wire logic [VEL_BITS-1:0]         target,
    input  wire logic [VEL_BITS-1:0]         lim,
    input  wire logic [cer_pkg::W_BITS-1:0]  weight,
    output logic      [VEL_BITS-1:0]         vel
);

    localparam int PW = VEL_BITS + cer_pkg::W_BITS + 2;

    logic signed [VEL_BITS-1:0] start_reg, target_reg, last_reg;
    logic signed [VEL_BITS-1:0] tgt_s, lim_s, nlim_s, clamped;
    logic signed [VEL_BITS:0]   diff;
    logic signed [PW-1:0]       prod;
    logic        [PW-1:0]       mag, rnd;
    logic        [VEL_BITS:0]   r;
    logic signed [VEL_BITS+1:0] v;

    // clamp to +/- lim
    always_comb begin
        tgt_s  = $signed(target);
        lim_s  = $signed(lim);
        nlim_s = -lim_s;
        if (tgt_s > lim_s) begin
            clamped = lim_s;
        end else if (tgt_s < nlim_s) begin
            clamped = nlim_s;
        end else begin
            clamped = tgt_s;
        end
    end

    // start + w * (target - start), rounded half away from zero
    always_comb begin
        diff = {target_reg[VEL_BITS-1], target_reg} - {start_reg[VEL_BITS-1], start_reg};
        prod = $signed({1'b0, weight}) * diff;
        mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
        rnd  = mag + PW'(1 << (cer_pkg::W_FRAC - 1));
        r    = rnd[cer_pkg::W_FRAC +: VEL_BITS+1];
        v    = {{2{start_reg[VEL_BITS-1]}}, start_reg}
             + (prod[PW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r}));
    end

    assign vel = v[VEL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            target_reg <= '0;
            last_reg   <= '0;
        end else if (ctl.stop) begin
            start_reg  <= '0;
            target_reg <= '0;
            last_reg   <= '0;
        end else if (ctl.load) begin
            start_reg  <= last_reg;
            target_reg <= clamped;
        end else if (ctl.tick) begin
            last_reg   <= v[VEL_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/cosine_eased_velocity_ramp.sv
// Cosine eased velocity ramp for up to seven joints. A load transaction (tuser 1)
// clamps each target to +/- max_velocity and restarts the ramp from the last
// outputs; each tick transaction (tuser 0) returns one result with every joint
// at start + w*(target - start), w following a half cosine over RAMP_STEPS
// ticks, and tuser high once the ramp had already finished; a stop transaction
// (tuser 2) zeroes all state and returns an all-zero result; tuser 3 is
// dropped. One transaction is taken every clock cycle while the result is
// not stalled; a result passes the input register, then one pass of multiply,
// round and add per joint into the result register. The weight rom is read
// ahead at the next step, so back-to-back ticks run at full rate.
// depends on cer_pkg, cer_weight_rom and cer_joint
`default_nettype none

module cosine_eased_velocity_ramp #(
    parameter int JOINTS     = 7,
    parameter int RAMP_STEPS = 256,
    parameter int VEL_BITS   = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // target_j0 .. target_j6, VEL_BITS each, zero padded to bytes
    input  wire logic [((cer_pkg::MAX_JOINTS*VEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]                               s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // vel_j0 .. vel_j6, VEL_BITS each, zero padded to bytes
    output logic      [((cer_pkg::MAX_JOINTS*VEL_BITS+7)/8)*8-1:0] m_axis_tdata,
    // ramp_done
    output logic      [0:0]                               m_axis_tuser,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [cer_pkg::CFG_ADDR_W-1:0]           paddr,
    input  wire logic [cer_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic      [cer_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                          pready
);

    localparam int TDATA_W = ((cer_pkg::MAX_JOINTS * VEL_BITS + 7) / 8) * 8;
    localparam int VCAT_W  = cer_pkg::MAX_JOINTS * VEL_BITS;
    localparam int SW      = $clog2(RAMP_STEPS + 1);
    localparam logic [SW-1:0] STEP_END = SW'(RAMP_STEPS);
    localparam logic [32:0]   VMAX     = (33'd1 << (VEL_BITS - 1)) - 33'd1;

    // configuration
    logic [cer_pkg::MAX_VEL_W-1:0] max_vel_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_vel_reg <= cer_pkg::MAX_VEL_RESET;
        end else if (cfg_wr && paddr[2] == cer_pkg::REG_MAX_VEL) begin
            max_vel_reg <= pwdata[cer_pkg::MAX_VEL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == cer_pkg::REG_MAX_VEL) ?
                    cer_pkg::CFG_DATA_W'(max_vel_reg) : '0;

    logic [32:0]         mv_ext;
    logic [VEL_BITS-1:0] lim;
    assign mv_ext = 33'(max_vel_reg);
    assign lim    = VEL_BITS'((mv_ext > VMAX) ? VMAX : mv_ext);

    // input register
    logic               in_valid_reg;
    logic [1:0]         in_cmd_reg;
    logic [VCAT_W-1:0]  in_tgt_reg;
    logic               needs_out, advance, s_acc;

    assign needs_out = (in_cmd_reg == cer_pkg::CMD_TICK) || (in_cmd_reg == cer_pkg::CMD_STOP);
    assign advance   = in_valid_reg && (!needs_out || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_acc     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_cmd_reg <= s_axis_tuser;
            in_tgt_reg <= s_axis_tdata[VCAT_W-1:0];
        end
    end

    cer_pkg::cer_ctl_t ctl;
    assign ctl.load = advance && (in_cmd_reg == cer_pkg::CMD_LOAD);
    assign ctl.tick = advance && (in_cmd_reg == cer_pkg::CMD_TICK);
    assign ctl.stop = advance && (in_cmd_reg == cer_pkg::CMD_STOP);

    // step counter and weight prefetch
    logic [SW-1:0]             step_count_reg, step_next, rom_addr;
    logic [cer_pkg::W_BITS-1:0] weight;
    logic                       ramp_done;

    assign ramp_done = (step_count_reg == STEP_END);

    always_comb begin
        step_next = step_count_reg;
        if (ctl.load || ctl.stop) begin
            step_next = '0;
        end else if (ctl.tick && !ramp_done) begin
            step_next = SW'(step_count_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_END;
        end else begin
            step_count_reg <= step_next;
        end
    end

    assign rom_addr = aresetn ? step_next : STEP_END;

    cer_weight_rom #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .weight  (weight)
    );

    // joint lanes
    logic [VCAT_W-1:0] vel_cat;

    for (genvar j = 0; j < cer_pkg::MAX_JOINTS; j++) begin : g_joint
        if (j < JOINTS) begin : g_lane
            cer_joint #(
                .VEL_BITS (VEL_BITS)
            ) u_joint (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .target  (in_tgt_reg[j*VEL_BITS +: VEL_BITS]),
                .lim     (lim),
                .weight  (weight),
                .vel     (vel_cat[j*VEL_BITS +: VEL_BITS])
            );
        end else begin : g_off
            assign vel_cat[j*VEL_BITS +: VEL_BITS] = '0;
        end
    end

    // result register
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    logic               m_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && needs_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.tick) begin
            m_data_reg <= TDATA_W'(vel_cat);
            m_done_reg <= ramp_done;
        end else if (ctl.stop) begin
            m_data_reg <= '0;
            m_done_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_done_reg;

    // checks
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_count_reg <= STEP_END)
        else $error("step counter beyond ramp end");

    a_load_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> step_count_reg == '0)
        else $error("load did not restart ramp");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.stop |=> m_axis_tvalid && m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("stop result not zero");

    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.tick && ramp_done |=> m_axis_tvalid && m_axis_tuser[0])
        else $error("ramp done flag missing");

endmodule

`default_nettype wire
